// ===== hdl/cwsc_pkg.sv =====
package cwsc_pkg;

  // field widths
  localparam int BASE_W  = 8;
  localparam int CNT_W   = 24;
  localparam int SEQ_W   = 32;
  localparam int STEP_W  = 24;
  localparam int POS_W   = 25;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam int TALLY_BITS_DEF = 24;

  // register reset values
  localparam logic [STEP_W-1:0] WINDOW_STEP_RST = STEP_W'(100);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_STEP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_LENGTH  = 1'b1;

  // bit-coded bases
  localparam logic [BASE_W-1:0] BASE_C      = 8'd40;
  localparam logic [BASE_W-1:0] BASE_PYR    = 8'd48;
  localparam logic [BASE_W-1:0] BASE_G      = 8'd72;
  localparam logic [BASE_W-1:0] BASE_PUR    = 8'd192;
  localparam logic [BASE_W-1:0] BASE_KETO   = 8'd80;
  localparam logic [BASE_W-1:0] BASE_STRONG = 8'd96;
  localparam logic [BASE_W-1:0] BASE_WEAK   = 8'd144;
  localparam logic [BASE_W-1:0] BASE_AMINO  = 8'd160;

  typedef struct packed {
    logic [BASE_W-1:0] base_code;
    logic              last_of_sequence;
  } item_t;

  typedef struct packed {
    logic [STEP_W-1:0] window_step;
    logic [SEQ_W-1:0]  sequence_length;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] cpg_pairs;
    logic [CNT_W-1:0] cpg_transitions;
    logic [SEQ_W-1:0] non_cpg_sites;
    logic [CNT_W-1:0] non_cpg_transitions;
    logic [CNT_W-1:0] transversions;
  } result_t;

endpackage

// ===== hdl/cwsc_in_if.sv =====
interface cwsc_in_if;
  logic                         valid;
  logic                         ready;
  logic [cwsc_pkg::BASE_W-1:0]  base_code;
  logic                         last_of_sequence;

  modport source (output valid, output base_code, output last_of_sequence, input ready);
  modport sink (input valid, input base_code, input last_of_sequence, output ready);
endinterface

// ===== hdl/cwsc_out_if.sv =====
interface cwsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [cwsc_pkg::CNT_W-1:0]  cpg_pairs;
  logic [cwsc_pkg::CNT_W-1:0]  cpg_transitions;
  logic [cwsc_pkg::SEQ_W-1:0]  non_cpg_sites;
  logic [cwsc_pkg::CNT_W-1:0]  non_cpg_transitions;
  logic [cwsc_pkg::CNT_W-1:0]  transversions;

  modport source (output valid, output cpg_pairs, output cpg_transitions,
                  output non_cpg_sites, output non_cpg_transitions,
                  output transversions, input ready);
  modport sink (input valid, input cpg_pairs, input cpg_transitions,
                input non_cpg_sites, input non_cpg_transitions,
                input transversions, output ready);
endinterface

// ===== hdl/cwsc_cfg_if.sv =====
interface cwsc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cwsc_pkg::CFG_IDX_W-1:0]   index;
  logic [cwsc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/cwsc_cfg_regs.sv =====
module cwsc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [cwsc_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [cwsc_pkg::CFG_DATA_W-1:0]  wr_data,
  output cwsc_pkg::cfg_t                   cfg
);

  logic [cwsc_pkg::STEP_W-1:0] window_step_r;
  logic [cwsc_pkg::SEQ_W-1:0]  seq_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_step_r <= cwsc_pkg::WINDOW_STEP_RST;
      seq_length_r  <= '0;
    end else if (wr_en) begin
      case (wr_index)
        cwsc_pkg::REG_WINDOW_STEP: window_step_r <= wr_data[cwsc_pkg::STEP_W-1:0];
        cwsc_pkg::REG_SEQ_LENGTH:  seq_length_r  <= wr_data[cwsc_pkg::SEQ_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.window_step     = window_step_r;
  assign cfg.sequence_length = seq_length_r;

endmodule

// ===== hdl/cwsc_in_stage.sv =====
module cwsc_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cwsc_pkg::item_t in_item,
  output logic            s1_valid,
  input  logic            s1_take,
  output cwsc_pkg::item_t s1_item
);

  logic            valid_r, valid_nxt;
  cwsc_pkg::item_t item_r;
  logic            in_fire;

  // refill in the same cycle the held request moves on
  assign in_ready  = !valid_r || s1_take;
  assign in_fire   = in_valid && in_ready;
  assign valid_nxt = in_fire || (valid_r && !s1_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// ===== hdl/cwsc_scan_core.sv =====
module cwsc_scan_core #(
  parameter int TALLY_BITS = cwsc_pkg::TALLY_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cwsc_pkg::cfg_t    cfg,
  input  logic              s1_valid,
  input  cwsc_pkg::item_t   s1_item,
  output logic              s1_take,
  output logic              out_valid,
  input  logic              out_ready,
  output cwsc_pkg::result_t out_result
);

  localparam int CNT_W = cwsc_pkg::CNT_W;
  localparam int SEQ_W = cwsc_pkg::SEQ_W;
  localparam int POS_W = cwsc_pkg::POS_W;

  logic [cwsc_pkg::BASE_W-1:0] held_base_r, held_base_nxt;
  logic                        held_valid_r, held_valid_nxt;
  logic [POS_W-1:0]            pos_r, pos_adv, pos_nxt;
  logic [TALLY_BITS-1:0]       cpg_r, cpgt_r, nct_r, tv_r;
  logic [TALLY_BITS-1:0]       cpg_sat, cpgt_sat, nct_sat, tv_sat;
  logic [TALLY_BITS-1:0]       cpg_nxt, cpgt_nxt, nct_nxt, tv_nxt;
  logic [TALLY_BITS:0]         cpg_sum, cpgt_sum, nct_sum, tv_sum;
  logic [1:0]                  cpgt_inc;
  logic [cwsc_pkg::BASE_W-1:0] a, b;
  logic                        a_cpg_first, b_cpg_second, is_pair, single, emit;
  logic                        a_trans, a_tvers;
  logic [SEQ_W-1:0]            cpg_wide;
  logic                        out_valid_r;
  cwsc_pkg::result_t           result_r, result_nxt;

  assign a = held_base_r;
  assign b = s1_item.base_code;

  assign a_cpg_first  = (a == cwsc_pkg::BASE_C) || (a == cwsc_pkg::BASE_PYR);
  assign b_cpg_second = (b == cwsc_pkg::BASE_G) || (b == cwsc_pkg::BASE_PUR);
  assign is_pair = held_valid_r && a_cpg_first && b_cpg_second;
  assign single  = held_valid_r && !is_pair;

  assign a_trans = (a == cwsc_pkg::BASE_PYR) || (a == cwsc_pkg::BASE_PUR);
  assign a_tvers = (a == cwsc_pkg::BASE_KETO) || (a == cwsc_pkg::BASE_STRONG) ||
                   (a == cwsc_pkg::BASE_WEAK) || (a == cwsc_pkg::BASE_AMINO);

  assign cpgt_inc = is_pair ? (2'((a == cwsc_pkg::BASE_PYR)) + 2'((b == cwsc_pkg::BASE_PUR)))
                            : 2'd0;

  // saturating adds: carry out means the tally passed its top
  assign cpg_sum  = {1'b0, cpg_r}  + (TALLY_BITS+1)'(is_pair);
  assign cpgt_sum = {1'b0, cpgt_r} + (TALLY_BITS+1)'(cpgt_inc);
  assign nct_sum  = {1'b0, nct_r}  + (TALLY_BITS+1)'(single && a_trans);
  assign tv_sum   = {1'b0, tv_r}   + (TALLY_BITS+1)'(single && a_tvers);

  assign cpg_sat  = cpg_sum[TALLY_BITS]  ? '1 : cpg_sum[TALLY_BITS-1:0];
  assign cpgt_sat = cpgt_sum[TALLY_BITS] ? '1 : cpgt_sum[TALLY_BITS-1:0];
  assign nct_sat  = nct_sum[TALLY_BITS]  ? '1 : nct_sum[TALLY_BITS-1:0];
  assign tv_sat   = tv_sum[TALLY_BITS]   ? '1 : tv_sum[TALLY_BITS-1:0];

  assign pos_adv = pos_r + (is_pair ? POS_W'(2) : POS_W'(single));
  assign emit    = held_valid_r && (pos_adv >= POS_W'(cfg.window_step));

  assign held_valid_nxt = is_pair ? 1'b0 : !s1_item.last_of_sequence;
  assign held_base_nxt  = held_valid_nxt ? b : '0;

  assign cpg_nxt  = emit ? '0 : cpg_sat;
  assign cpgt_nxt = emit ? '0 : cpgt_sat;
  assign nct_nxt  = emit ? '0 : nct_sat;
  assign tv_nxt   = emit ? '0 : tv_sat;
  assign pos_nxt  = emit ? '0 : pos_adv;

  assign cpg_wide = SEQ_W'(cpg_sat);

  always_comb begin
    result_nxt.cpg_pairs           = CNT_W'(cpg_sat);
    result_nxt.cpg_transitions     = CNT_W'(cpgt_sat);
    result_nxt.non_cpg_sites       = (cfg.sequence_length >= cpg_wide) ?
                                     (cfg.sequence_length - cpg_wide) : '0;
    result_nxt.non_cpg_transitions = CNT_W'(nct_sat);
    result_nxt.transversions       = CNT_W'(tv_sat);
  end

  // a request with no record never waits on the output side
  assign s1_take = s1_valid && (!emit || !out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_base_r  <= '0;
      held_valid_r <= 1'b0;
      pos_r        <= '0;
      cpg_r        <= '0;
      cpgt_r       <= '0;
      nct_r        <= '0;
      tv_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (s1_take) begin
        held_base_r  <= held_base_nxt;
        held_valid_r <= held_valid_nxt;
        pos_r        <= pos_nxt;
        cpg_r        <= cpg_nxt;
        cpgt_r       <= cpgt_nxt;
        nct_r        <= nct_nxt;
        tv_r         <= tv_nxt;
      end
      if (s1_take && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && emit) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = result_r;

endmodule

// ===== hdl/cpg_window_site_counter_top.sv =====
// CpG window site counter. One bit-coded base byte is taken per request on in_bus
// together with a flag that marks the last byte of a sequence. Bytes are scanned
// in pairs: a C or Y byte followed by G or R makes one CpG site and both are used
// up; any other byte is scanned alone and counts a non-CpG transition (Y, R) or a
// transversion (K, S, W, M). Every scanned byte advances a position count; when it
// reaches window_step (register 0) one record of five counts leaves on out_bus and
// the tallies start again. non_cpg_sites is sequence_length (register 1) minus the
// CpG count, floored at zero. Tallies saturate and carry across sequences. A byte
// is caught in the input register at the edge that accepts it and is scanned from
// there; the scan step that closes a window also loads the record register, from
// which the record is presented. The block takes one byte every clock, limited
// only by the single scan step that updates the tallies, and stalls only when a
// record is due while the previous one is still unread. Configuration writes are
// always taken and must be made while the block is idle.
module cpg_window_site_counter_top #(
  parameter int TALLY_BITS = cwsc_pkg::TALLY_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  cwsc_in_if.sink  in_bus,
  cwsc_out_if.source out_bus,
  cwsc_cfg_if.sink cfg_bus
);

  cwsc_pkg::cfg_t    cfg;
  cwsc_pkg::item_t   in_item;
  cwsc_pkg::item_t   s1_item;
  cwsc_pkg::result_t result;
  logic              s1_valid;
  logic              s1_take;
  logic              in_ready;
  logic              out_valid;

  // register writes never stall
  assign cfg_bus.ready = 1'b1;

  cwsc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_bus.valid),
    .wr_index (cfg_bus.index),
    .wr_data  (cfg_bus.data),
    .cfg      (cfg)
  );

  assign in_item.base_code        = in_bus.base_code;
  assign in_item.last_of_sequence = in_bus.last_of_sequence;
  assign in_bus.ready             = in_ready;

  // input register
  cwsc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .s1_valid (s1_valid),
    .s1_take  (s1_take),
    .s1_item  (s1_item)
  );

  // pairing, tallies, window check and record register
  cwsc_scan_core #(
    .TALLY_BITS (TALLY_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item),
    .s1_take    (s1_take),
    .out_valid  (out_valid),
    .out_ready  (out_bus.ready),
    .out_result (result)
  );

  assign out_bus.valid               = out_valid;
  assign out_bus.cpg_pairs           = result.cpg_pairs;
  assign out_bus.cpg_transitions     = result.cpg_transitions;
  assign out_bus.non_cpg_sites       = result.non_cpg_sites;
  assign out_bus.non_cpg_transitions = result.non_cpg_transitions;
  assign out_bus.transversions       = result.transversions;

endmodule

// ===== hdl/cwsc_checker.sv =====
module cwsc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cwsc_pkg::CNT_W-1:0]  cpg_pairs,
  input logic [cwsc_pkg::CNT_W-1:0]  cpg_transitions,
  input logic [cwsc_pkg::SEQ_W-1:0]  non_cpg_sites
);

  // a record waiting on the sink stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("record dropped while stalled");

  // stalled record keeps its counts
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(cpg_pairs) && $stable(cpg_transitions) &&
                                $stable(non_cpg_sites))
    else $error("record changed while stalled");

  // at most two transitions per cpg site
  a_trans_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({2'b00, cpg_transitions} <= {1'b0, cpg_pairs, 1'b0}))
    else $error("cpg transitions exceed twice the site count");

  // no cpg site means no cpg transition
  a_trans_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (cpg_pairs == '0) |-> (cpg_transitions == '0))
    else $error("cpg transitions without a site");

endmodule

bind cpg_window_site_counter_top cwsc_checker u_cwsc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .cpg_pairs       (out_bus.cpg_pairs),
  .cpg_transitions (out_bus.cpg_transitions),
  .non_cpg_sites   (out_bus.non_cpg_sites)
);
